[hdl/base64_stream_decoder_unit_assert.svh]
// Assertion macros for the Base64 stream decoder.
// Depends on nothing; expects signals clk and rst_n in the including module.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising edge of clk outside of reset.
`define B64SD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("b64sd assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define B64SD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64sd implication failed");

// Checks that a condition implies a consequence in the next cycle.
`define B64SD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64sd next-cycle implication failed");

`else

`define B64SD_ASSERT(lbl, prop)
`define B64SD_ASSERT_IMPL(lbl, ante, cons)
`define B64SD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/b64sd_pkg.sv]
// Shared types, constants and the alphabet lookup of the Base64 stream decoder.
// Depends on nothing.
package b64sd_pkg;

  // Width of the internal decoded-byte counter; the reported count is 16 bits.
  localparam int COUNT_WIDTH = 16;
  localparam int REPORT_WIDTH = 16;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef logic [1:0] phase_t;
  localparam phase_t PHASE_ZERO  = 2'd0;
  localparam phase_t PHASE_ONE   = 2'd1;
  localparam phase_t PHASE_TWO   = 2'd2;
  localparam phase_t PHASE_THREE = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic       en;
    logic [7:0] in_char;
    logic       is_last;
  } step_t;

  typedef struct packed {
    logic [7:0]              out_byte;
    logic                    byte_valid;
    logic                    decode_error;
    logic                    done_res;
    logic [REPORT_WIDTH-1:0] byte_count;
  } result_t;

  // Maps a character of the standard alphabet to its 6-bit value.
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.hit = 1'b1;
    s.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.val = 6'd63;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

endpackage

[hdl/b64sd_if.sv]
// Valid/ready channel interfaces for the Base64 stream decoder.
// Depends on b64sd_pkg for the count width.
interface b64sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       is_last;

  modport source (output valid, output in_char, output is_last, input ready);
  modport sink   (input valid, input in_char, input is_last, output ready);
endinterface

interface b64sd_out_if;
  logic                              valid;
  logic                              ready;
  logic [7:0]                        out_byte;
  logic                              byte_valid;
  logic                              decode_error;
  logic                              done_res;
  logic [b64sd_pkg::REPORT_WIDTH-1:0] byte_count;

  modport source (output valid, output out_byte, output byte_valid, output decode_error,
                  output done_res, output byte_count, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input decode_error,
                  input done_res, input byte_count, output ready);
endinterface

[hdl/b64sd_core.sv]
// Decoder state and the per-character decode logic of the Base64 stream decoder.
// Depends on b64sd_pkg and base64_stream_decoder_unit_assert.svh.
`include "base64_stream_decoder_unit_assert.svh"

module b64sd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  b64sd_pkg::step_t   step,
  output b64sd_pkg::result_t res
);

  localparam int CW = b64sd_pkg::COUNT_WIDTH;
  localparam int RW = b64sd_pkg::REPORT_WIDTH;

  b64sd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]        partial_r, partial_nxt;
  logic              pad_pending_r, pad_pending_nxt;
  logic              failed_r, failed_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  b64sd_pkg::sextet_t sx;
  logic [7:0]         byte_out;
  logic               byte_ok;
  logic [CW+RW-1:0]   count_ext;

  always_comb begin
    sx              = b64sd_pkg::sextet_of(step.in_char);
    phase_nxt       = phase_r;
    partial_nxt     = partial_r;
    pad_pending_nxt = pad_pending_r;
    failed_nxt      = failed_r;
    count_nxt       = count_r;
    byte_out        = 8'h00;
    byte_ok         = 1'b0;

    if (!failed_r) begin
      pad_pending_nxt = 1'b0;
      // A pad at phase one must be followed directly by a second pad.
      if (pad_pending_r && step.in_char != b64sd_pkg::PAD_CHAR) begin
        failed_nxt = 1'b1;
      end else if (step.in_char == b64sd_pkg::PAD_CHAR) begin
        if (phase_r == b64sd_pkg::PHASE_ONE) begin
          if (step.is_last) begin
            failed_nxt = 1'b1;
          end else begin
            pad_pending_nxt = 1'b1;
          end
        end
      end else if (sx.hit) begin
        unique case (phase_r)
          b64sd_pkg::PHASE_ZERO: begin
            partial_nxt = {sx.val, 2'b00};
          end
          b64sd_pkg::PHASE_ONE: begin
            byte_out    = partial_r | {6'b0, sx.val[5:4]};
            partial_nxt = {sx.val[3:0], 4'b0};
            byte_ok     = 1'b1;
          end
          b64sd_pkg::PHASE_TWO: begin
            byte_out    = partial_r | {4'b0, sx.val[5:2]};
            partial_nxt = {sx.val[1:0], 6'b0};
            byte_ok     = 1'b1;
          end
          b64sd_pkg::PHASE_THREE: begin
            byte_out = partial_r | {2'b0, sx.val};
            byte_ok  = 1'b1;
          end
        endcase
        phase_nxt = phase_r + 2'd1;
        if (byte_ok && count_r != {CW{1'b1}}) begin
          count_nxt = count_r + CW'(1);
        end
      end
    end
  end

  always_comb begin
    count_ext        = {{RW{1'b0}}, count_nxt};
    res.out_byte     = byte_out;
    res.byte_valid   = byte_ok;
    res.decode_error = failed_nxt;
    res.done_res     = step.is_last;
    res.byte_count   = count_ext[RW-1:0];
  end

  // The last character of a string returns the whole state to its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= b64sd_pkg::PHASE_ZERO;
      partial_r     <= 8'h00;
      pad_pending_r <= 1'b0;
      failed_r      <= 1'b0;
      count_r       <= '0;
    end else if (step.en) begin
      if (step.is_last) begin
        phase_r       <= b64sd_pkg::PHASE_ZERO;
        partial_r     <= 8'h00;
        pad_pending_r <= 1'b0;
        failed_r      <= 1'b0;
        count_r       <= '0;
      end else begin
        phase_r       <= phase_nxt;
        partial_r     <= partial_nxt;
        pad_pending_r <= pad_pending_nxt;
        failed_r      <= failed_nxt;
        count_r       <= count_nxt;
      end
    end
  end

  `B64SD_ASSERT_NEXT(a_error_sticky, failed_r && !(step.en && step.is_last), failed_r)
  `B64SD_ASSERT_NEXT(a_clear_on_last, step.en && step.is_last,
    phase_r == b64sd_pkg::PHASE_ZERO && count_r == '0 && !pad_pending_r && !failed_r)
  `B64SD_ASSERT_IMPL(a_pad_at_phase_one, pad_pending_r, phase_r == b64sd_pkg::PHASE_ONE)
  `B64SD_ASSERT_IMPL(a_no_byte_on_error, res.byte_valid, !res.decode_error)
  `B64SD_ASSERT(a_pad_clean, !(pad_pending_r && failed_r))

endmodule

[hdl/base64_stream_decoder_unit.sv]
// Base64 stream decoder: takes one character per transfer and returns one result per
// character. An input register feeds the decode logic, whose result lands in an output
// register; the packer state advances when a character moves from the one to the other.
// A new character is taken every clock while results are taken, so throughput is one
// character per cycle; a character goes from the input register to the output register,
// and the packer state updates as it advances, which sets that rate. Each result carries
// the decoded byte if one completed, the sticky pad error, the end-of-string mark and the
// running count of decoded bytes.
// Depends on b64sd_pkg, b64sd_if and b64sd_core.
module base64_stream_decoder_unit (
  input  logic         clk,
  input  logic         rst_n,
  b64sd_in_if.sink     in_ch,
  b64sd_out_if.source  out_ch
);

  logic                s1_valid_r;
  logic [7:0]          s1_char_r;
  logic                s1_last_r;
  logic                out_valid_r;
  b64sd_pkg::result_t  out_res_r;
  b64sd_pkg::step_t    step;
  b64sd_pkg::result_t  res;
  logic                s1_adv;
  logic                in_xfer;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    step.en      = s1_adv;
    step.in_char = s1_char_r;
    step.is_last = s1_last_r;
  end

  b64sd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_char_r <= in_ch.in_char;
      s1_last_r <= in_ch.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_res_r.out_byte;
  assign out_ch.byte_valid   = out_res_r.byte_valid;
  assign out_ch.decode_error = out_res_r.decode_error;
  assign out_ch.done_res     = out_res_r.done_res;
  assign out_ch.byte_count   = out_res_r.byte_count;

endmodule

[bench/testbench.sv]
// Self-checking testbench for the Base64 stream decoder unit.
// Drives characters over the input channel, predicts every result and checks it field by field.
// Depends on b64sd_pkg, the b64sd_in_if and b64sd_out_if interfaces, and the decoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CW           = b64sd_pkg::COUNT_WIDTH;
  localparam int RW           = b64sd_pkg::REPORT_WIDTH;

  logic clk = 1'b0;
  logic rst_n;

  b64sd_in_if  in_ch ();
  b64sd_out_if out_ch ();

  base64_stream_decoder_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted decoder state.
  b64sd_pkg::phase_t dec_phase;
  logic [7:0]        dec_partial;
  logic              dec_pad_wait;
  logic              dec_failed;
  logic [CW-1:0]     dec_count;

  b64sd_pkg::result_t expected_results[$];
  logic [7:0]         text_q[$];
  logic [7:0]         b64_alphabet[64];
  int                 sextet_lut[256];
  logic [7:0]         blank_chars[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};

  int error_count;
  int burst_left;
  bit gaps_on;
  int idle_cycles;

  function automatic void clear_decoder();
    dec_phase    = b64sd_pkg::PHASE_ZERO;
    dec_partial  = 8'h00;
    dec_pad_wait = 1'b0;
    dec_failed   = 1'b0;
    dec_count    = '0;
  endfunction

  // Advances the predicted state by one character and returns the result it causes.
  function automatic b64sd_pkg::result_t decode_step(input logic [7:0] c, input logic last);
    b64sd_pkg::result_t r;
    logic               check_pad;
    logic [5:0]         sx;
    r = '0;
    r.done_res = last;
    if (!dec_failed) begin
      check_pad = dec_pad_wait;
      dec_pad_wait = 1'b0;
      if (check_pad && c != b64sd_pkg::PAD_CHAR) begin
        dec_failed = 1'b1;
      end else if (c == b64sd_pkg::PAD_CHAR) begin
        if (dec_phase == b64sd_pkg::PHASE_ONE) begin
          if (last) dec_failed = 1'b1;
          else dec_pad_wait = 1'b1;
        end
      end else if (sextet_lut[c] >= 0) begin
        sx = 6'(sextet_lut[c]);
        case (dec_phase)
          b64sd_pkg::PHASE_ZERO: begin
            dec_partial = {sx, 2'b00};
          end
          b64sd_pkg::PHASE_ONE: begin
            r.out_byte = dec_partial | {6'd0, sx[5:4]};
            dec_partial = {sx[3:0], 4'd0};
            r.byte_valid = 1'b1;
          end
          b64sd_pkg::PHASE_TWO: begin
            r.out_byte = dec_partial | {4'd0, sx[5:2]};
            dec_partial = {sx[1:0], 6'd0};
            r.byte_valid = 1'b1;
          end
          default: begin
            r.out_byte = dec_partial | {2'd0, sx};
            r.byte_valid = 1'b1;
          end
        endcase
        dec_phase = dec_phase + 2'd1;
        if (r.byte_valid && dec_count != {CW{1'b1}}) dec_count = dec_count + CW'(1);
      end
    end
    r.decode_error = dec_failed;
    r.byte_count = RW'(dec_count);
    if (last) clear_decoder();
    return r;
  endfunction

  // Presents one character and waits for its transfer; valid stays high inside a burst.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= c;
    in_ch.is_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(decode_step(c, last));
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void push_char(input logic [7:0] c, input int blank_pct);
    if ($urandom_range(0, 99) < blank_pct) text_q.push_back(blank_chars[$urandom_range(0, 3)]);
    text_q.push_back(c);
  endfunction

  // Appends the encoding of nbytes random bytes, with or without the trailing pads.
  function automatic void encode_bytes(input int nbytes, input bit keep_pad, input int blank_pct);
    logic [7:0] b0, b1, b2;
    logic [5:0] sx[4];
    int         n;
    for (int i = 0; i < nbytes; i += 3) begin
      n  = (nbytes - i < 3) ? nbytes - i : 3;
      b0 = 8'($urandom_range(0, 255));
      b1 = (n > 1) ? 8'($urandom_range(0, 255)) : 8'h00;
      b2 = (n > 2) ? 8'($urandom_range(0, 255)) : 8'h00;
      sx[0] = b0[7:2];
      sx[1] = {b0[1:0], b1[7:4]};
      sx[2] = {b1[3:0], b2[7:6]};
      sx[3] = b2[5:0];
      for (int j = 0; j <= n; j++) push_char(b64_alphabet[sx[j]], blank_pct);
      if (keep_pad) begin
        for (int j = n + 1; j < 4; j++) push_char(b64sd_pkg::PAD_CHAR, blank_pct);
      end
    end
  endfunction

  task automatic test_directed();
    // Plain group, then every alphabet class with skipped bytes and pads at phase two.
    push_str("TWFu");
    send_text();
    push_str("Zz09+/");
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    text_q.push_back(8'h09);
    text_q.push_back(8'h0A);
    push_str("==");
    send_text();
    // A pad at phase one followed by another pad, then one followed by a data character.
    push_str("Q== ");
    send_text();
    push_str("Q=BC");
    send_text();
    // A pad at phase one on the last character.
    push_str("Q=");
    send_text();
  endtask

  task automatic test_random_strings();
    int counted;
    int kind;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      gaps_on = ($urandom_range(0, 3) != 0);
      encode_bytes($urandom_range(0, 12), $urandom_range(0, 3) != 0,
                   $urandom_range(0, 1) ? 10 : 0);
      if (kind >= 70 && kind < 85) begin
        repeat ($urandom_range(1, 3))
          text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
      end else if (kind >= 85) begin
        if (text_q.size() > 0 && $urandom_range(0, 1))
          text_q[$urandom_range(0, text_q.size() - 1)] = b64sd_pkg::PAD_CHAR;
        else
          text_q.insert($urandom_range(0, text_q.size()), b64sd_pkg::PAD_CHAR);
      end
      if (text_q.size() == 0) text_q.push_back(blank_chars[$urandom_range(0, 3)]);
      foreach (text_q[i]) begin
        if (!(text_q[i] inside {blank_chars})) counted++;
      end
      send_text();
    end
    gaps_on = 1'b1;
  endtask

  // Result checker: every transfer on the output is matched against the oldest prediction.
  always @(posedge clk) begin : check_result
    b64sd_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no prediction pending");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_ch.out_byte);
          error_count++;
        end
        if (out_ch.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_ch.byte_valid);
          error_count++;
        end
        if (out_ch.decode_error !== want.decode_error) begin
          $error("decode_error: expected %0b, got %0b", want.decode_error, out_ch.decode_error);
          error_count++;
        end
        if (out_ch.done_res !== want.done_res) begin
          $error("done_res: expected %0b, got %0b", want.done_res, out_ch.done_res);
          error_count++;
        end
        if (out_ch.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, out_ch.byte_count);
          error_count++;
        end
      end
    end
  end

  // Receiver stalls follow a 16-bit pattern that is redrawn now and then.
  initial begin : result_stall
    logic [15:0] pattern;
    int          left;
    out_ch.ready = 1'b0;
    pattern = '1;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        case ($urandom_range(0, 3))
          0: pattern = '1;
          1: pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
          default: pattern = 16'($urandom) | 16'h0001;
        endcase
        left = 16 * $urandom_range(1, 8);
      end
      left--;
      out_ch.ready <= pattern[left % 16];
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("[base64_stream_decoder_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_char = 8'h00;
    in_ch.is_last = 1'b0;
    error_count   = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    foreach (sextet_lut[i]) sextet_lut[i] = -1;
    for (int i = 0; i < 64; i++) begin
      if (i < 26) b64_alphabet[i] = 8'h41 + 8'(i);
      else if (i < 52) b64_alphabet[i] = 8'h61 + 8'(i - 26);
      else if (i < 62) b64_alphabet[i] = 8'h30 + 8'(i - 52);
      else if (i == 62) b64_alphabet[i] = 8'h2B;
      else b64_alphabet[i] = 8'h2F;
      sextet_lut[b64_alphabet[i]] = i;
    end
    clear_decoder();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_strings();

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[base64_stream_decoder_unit] OK");
    end else begin
      $display("[base64_stream_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
